// ----- design/bcdb_pkg.sv -----
// Shared types, constants and helpers for the BCD integer to binary converter.
package bcdb_pkg;

  localparam int MAX_DIGITS  = 16;
  localparam int DIGIT_CNT_W = 5;   // holds 0..MAX_DIGITS
  localparam int VALUE_W     = 64;
  localparam int COUNT_W     = 7;   // holds 1..64
  localparam int PREC_W      = 6;
  localparam int BYTE_IDX_W  = 3;   // byte lanes of the value word

  localparam logic [PREC_W-1:0]      PREC_RESET  = 6'd63;
  localparam logic [DIGIT_CNT_W-1:0] DIGIT_LIMIT = 5'(MAX_DIGITS);

  // input beat: one BCD digit
  typedef struct packed {
    logic [3:0] digit;
    logic       last_digit;
  } in_item_t;

  // output beat: converted number
  typedef struct packed {
    logic [VALUE_W-1:0] binary_value;
    logic [COUNT_W-1:0] bit_count;
    logic               truncated;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_digit;   // take the digit of the current input beat
    logic scan_start;   // point the length scan at the top byte
    logic scan_step;    // examine one byte of the value
    logic finish;       // build the result beat and clear the number
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;    // the byte under examination is the leading one
    logic out_busy;     // result register full and stalled
  } status_t;

  // number of significant bits in one byte, 0..8
  function automatic logic [3:0] bitlen8(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        n = 4'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

// ----- design/bcdb_ctrl.sv -----
// Sequencer: digit loading, leading-byte scan and result hand-off.
module bcdb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_last,
  input  bcdb_pkg::status_t status,
  output logic            in_stall,
  output bcdb_pkg::cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0] state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    cmd.load_digit = 1'b0;
    cmd.scan_start = 1'b0;
    cmd.scan_step  = 1'b0;
    cmd.finish     = 1'b0;
    in_stall       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_digit = 1'b1;
          if (in_last) begin
            cmd.scan_start = 1'b1;
            state_next     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/bcdb_dp.sv -----
// Datapath: decimal accumulator, bit-length scan, truncation and result register.
module bcdb_dp (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [3:0]              in_digit,
  input  logic                    cfg_valid,
  input  logic [bcdb_pkg::PREC_W-1:0] cfg_data,
  input  bcdb_pkg::cmd_t          cmd,
  input  logic                    out_stall,
  output bcdb_pkg::status_t       status,
  output logic                    out_valid,
  output bcdb_pkg::out_item_t     out_data
);

  logic [bcdb_pkg::VALUE_W-1:0]     acc;
  logic [bcdb_pkg::DIGIT_CNT_W-1:0] cnt;
  logic                             ovf;
  logic [bcdb_pkg::BYTE_IDX_W-1:0]  byte_idx;
  logic [bcdb_pkg::COUNT_W-1:0]     len;
  logic [bcdb_pkg::PREC_W-1:0]      precision;

  logic [bcdb_pkg::VALUE_W-1:0]     acc_next;
  logic [7:0]                       cur_byte;
  logic [bcdb_pkg::BYTE_IDX_W-1:0]  lane;
  logic                             scan_hit;
  logic [bcdb_pkg::COUNT_W-1:0]     len_next;
  logic [bcdb_pkg::COUNT_W-1:0]     keep;
  bcdb_pkg::out_item_t              result;

  // precision register
  always_ff @(posedge clk) begin
    if (rst) begin
      precision <= bcdb_pkg::PREC_RESET;
    end else if (cfg_valid) begin
      precision <= cfg_data;
    end
  end

  // acc * 10 + digit
  assign acc_next = {acc[bcdb_pkg::VALUE_W-4:0], 3'b000}
                  + {acc[bcdb_pkg::VALUE_W-2:0], 1'b0}
                  + {{(bcdb_pkg::VALUE_W-4){1'b0}}, in_digit};

  // digit accumulation, dropped-digit flag
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
      ovf <= 1'b0;
    end else if (cmd.finish) begin
      acc <= '0;
      cnt <= '0;
      ovf <= 1'b0;
    end else if (cmd.load_digit) begin
      if (cnt < bcdb_pkg::DIGIT_LIMIT) begin
        acc <= acc_next;
        cnt <= cnt + 1'b1;
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  // leading byte scan, top lane first
  assign lane      = ~byte_idx;
  assign cur_byte  = acc[{lane, 3'b000} +: 8];
  assign scan_hit  = (cur_byte != 8'd0) || (byte_idx == {bcdb_pkg::BYTE_IDX_W{1'b1}});
  assign len_next  = {1'b0, lane, 3'b000} + {3'b000, bcdb_pkg::bitlen8(cur_byte)};
  assign status.scan_done = scan_hit;

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      byte_idx <= '0;
    end else if (cmd.scan_step) begin
      byte_idx <= byte_idx + 1'b1;
      if (scan_hit) begin
        len <= len_next;
      end
    end
  end

  // result: zero, fits, or cut to precision+1 bits
  assign keep = {1'b0, precision} + 1'b1;

  always_comb begin
    result.binary_value = acc;
    result.bit_count    = len;
    result.truncated    = ovf;
    if (len == '0) begin
      result.bit_count = 7'd1;
    end else if (len > keep) begin
      result.bit_count    = keep;
      result.binary_value = acc & ~({bcdb_pkg::VALUE_W{1'b1}} << keep);
      result.truncated    = 1'b1;
    end
  end

  // output register
  assign status.out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data <= result;
    end
  end

endmodule

// ----- design/bcd_integer_to_binary.sv -----
// Top level of the BCD integer to binary converter.
// Input channel (in_valid/in_stall/in_data): one BCD digit per beat, most
// significant first; last_digit marks the final digit of a number. Digits
// beyond the sixteenth are dropped and flag the result as truncated.
// Output channel (out_valid/out_stall/out_data): one beat per number with the
// binary value, its bit count (1 for zero) and the truncated flag. At most
// precision+1 low bits are kept; a longer value is cut and flagged.
// Configuration channel (cfg_valid/cfg_ready/cfg_data): writes precision;
// always ready. Users must write it only while the block is idle (the block
// does not enforce this). Reset value 63. Digit beats are taken back to back
// while the block is idle. After the last digit, a scan for the leading
// nonzero byte of the 64-bit accumulator runs one byte per cycle from the top
// byte down, stopping at the first nonzero byte or the bottom byte; the result
// is then built and loaded once the output register is not stalled. The input
// is stalled from the last digit until the result is in the output register.
// A stalled result holds in the output register; the next number's digits are
// taken meanwhile, but its result waits until the register empties.
// Reset (rst, synchronous) clears the pending number and the output beat.
module bcd_integer_to_binary (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  bcdb_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output bcdb_pkg::out_item_t          out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [bcdb_pkg::PREC_W-1:0]  cfg_data
);

  bcdb_pkg::cmd_t    cmd;
  bcdb_pkg::status_t status;

  assign cfg_ready = 1'b1;

  // sequencer
  bcdb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (in_data.last_digit),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // datapath
  bcdb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_digit  (in_data.digit),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .out_stall (out_stall),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
